@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL, clocked on clk and off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/sflt_pkg.sv @@
// Types and constants of the symbol floor lookup table.
package sflt_pkg;

	localparam int TABLE_DEPTH = 8192;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = IDX_W + 1;
	localparam int OUT_IDX_W = 13;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_FLOOR  = 2'd2;
	localparam logic [1:0] CMD_EXACT  = 2'd3;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] address;
		logic [31:0] name_tag;
	} req_t;

	typedef struct packed {
		logic                 found;
		logic [OUT_IDX_W-1:0] entry_index;
		logic [63:0]          entry_address;
		logic [31:0]          entry_name;
		logic [63:0]          offset;
		logic                 status;
	} rsp_t;

endpackage

@@ rtl/core/symbol_floor_lookup_table.sv @@
// Symbol floor lookup table: entry store, linear scan and result register.
//
//  channel  | handshake          | word
//  ---------+--------------------+-------------------------------------
//  command  | start / busy       | req  (command, address, name_tag)
//  result   | done (one cycle)   | rsp  (found .. offset, status)
//
// Clear and append need no scan; the result shows the cycle after start and busy stays low.
// Lookup and exact test read one entry per cycle from the address/name memories:
// busy while the scan runs, result in the same cycle that busy falls.
// An exact test stops at its first match. With an empty table no scan runs: busy stays low.
// Reset empties the table (count to zero); the memories are not cleared.
// The receiver cannot stall: each result is shown for one cycle only.
`include "assert_macros.svh"

module symbol_floor_lookup_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  sflt_pkg::req_t req,
	output logic           done,
	output sflt_pkg::rsp_t rsp
);
	import sflt_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [63:0] mem_addr [TABLE_DEPTH];
	logic [31:0] mem_name [TABLE_DEPTH];

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_ptr_q;
	logic             exact_q;
	logic [63:0]      query_q;

	logic             valid_s1;
	logic             last_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [63:0]      addr_s1;
	logic [31:0]      name_s1;

	logic             hit_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [63:0]      best_addr_q;
	logic [31:0]      best_name_q;

	logic done_q;
	rsp_t rsp_q;
	rsp_t start_rsp;
	rsp_t scan_rsp;

	logic accept, full, do_append, issue, floor_hit, exact_hit, take, finish;

	assign accept    = start && (state_q == ST_IDLE);
	assign full      = (count_q == CNT_W'(TABLE_DEPTH));
	assign do_append = accept && (req.command == CMD_APPEND) && !full;
	assign issue     = (state_q == ST_SCAN) && (rd_ptr_q != count_q);
	assign floor_hit = (addr_s1 <= query_q) && (addr_s1 > best_addr_q);
	assign exact_hit = (addr_s1 == query_q);
	assign take      = valid_s1 && (state_q == ST_SCAN) && (exact_q ? exact_hit : floor_hit);
	assign finish    = valid_s1 && (state_q == ST_SCAN) && (last_s1 || (exact_q && exact_hit));

	// result word for a command that needs no scan, and for the end of a scan
	always_comb begin
		start_rsp = '0;
		if (req.command == CMD_APPEND && full)
			start_rsp.status = STATUS_FULL;
		else
			start_rsp.status = STATUS_OK;
		scan_rsp = '0;
		scan_rsp.status = STATUS_OK;
		if (hit_q) begin
			scan_rsp.found         = 1'b1;
			scan_rsp.entry_index   = OUT_IDX_W'(best_idx_q);
			scan_rsp.entry_address = best_addr_q;
			scan_rsp.entry_name    = best_name_q;
			scan_rsp.offset        = query_q - best_addr_q;
		end
	end

	// entry store: one write port for append, one read port for the scan
	always_ff @(posedge clk) begin
		if (do_append) begin
			mem_addr[count_q[IDX_W-1:0]] <= req.address;
			mem_name[count_q[IDX_W-1:0]] <= req.name_tag;
		end
		if (issue) begin
			addr_s1 <= mem_addr[rd_ptr_q[IDX_W-1:0]];
			name_s1 <= mem_name[rd_ptr_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			rd_ptr_q <= '0;
			valid_s1 <= 1'b0;
			hit_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= issue;
			done_q   <= 1'b0;
			if (issue)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (take)
				hit_q <= 1'b1;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req.command)
							CMD_CLEAR: begin
								count_q <= '0;
								done_q  <= 1'b1;
							end
							CMD_APPEND: begin
								if (!full)
									count_q <= count_q + 1'b1;
								done_q <= 1'b1;
							end
							CMD_FLOOR, CMD_EXACT: begin
								rd_ptr_q <= '0;
								hit_q    <= 1'b0;
								if (count_q == '0)
									done_q <= 1'b1;
								else
									state_q <= ST_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (finish)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload: query, running best, pipeline tags and the result word
	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1  <= rd_ptr_q[IDX_W-1:0];
			last_s1 <= (CNT_W'(rd_ptr_q + 1'b1) == count_q);
		end
		if (take) begin
			best_idx_q  <= idx_s1;
			best_addr_q <= addr_s1;
			best_name_q <= name_s1;
		end
		if (accept) begin
			query_q     <= req.address;
			exact_q     <= (req.command == CMD_EXACT);
			best_addr_q <= '0;
			rsp_q       <= start_rsp;
		end
		if (state_q == ST_FIN)
			rsp_q <= scan_rsp;
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	`ASSERT_IMPL(a_no_done_in_scan, state_q == ST_SCAN, !done, "result during scan")
	`ASSERT_IMPL(a_count_in_range, 1'b1, count_q <= CNT_W'(TABLE_DEPTH), "count above depth")
	`ASSERT_NEXT(a_append_counts, do_append, count_q == CNT_W'($past(count_q) + 1'b1), "append lost")
	`ASSERT_IMPL(a_read_in_scan, valid_s1, $past(state_q) == ST_SCAN, "read outside scan")

endmodule
